// ===== sv/fir_filter_stream_core_assert.svh =====
// Assertion macros shared by the filter RTL.
// Each macro expects clk_i, and FIRS_ASSERT also rst_ni, to be visible at the point of use.
`ifndef FIR_FILTER_STREAM_CORE_ASSERT_SVH
`define FIR_FILTER_STREAM_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FIRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FIRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/firs_pkg.sv =====
`timescale 1ns / 1ps

package firs_pkg;

  // Filter length limits
  localparam int unsigned Taps     = 8;
  localparam int unsigned MaxTaps  = 8;
  localparam int unsigned NumCoeff = 8;

  // Data widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CoeffW    = 18;
  localparam int unsigned ProdW     = SampleW + CoeffW;
  localparam int unsigned AccW      = ProdW + $clog2(MaxTaps);
  localparam int unsigned FracShift = 16;
  localparam int unsigned CfgIdxW   = $clog2(NumCoeff);

  // Coefficient 1.0 in Q2.16, reset value of the current-sample weight
  localparam logic signed [CoeffW-1:0] CoeffOne = CoeffW'(65536);

  typedef enum logic {
    FUNC_FILTER = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_e;

  typedef struct packed {
    func_e                     func;
    logic signed [SampleW-1:0] sample_in;
    logic                      block_end;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      saturated;
    logic                      block_end_out;
  } out_t;

endpackage

// ===== sv/firs_sum.sv =====
`timescale 1ns / 1ps

module firs_sum #(
  parameter int unsigned Taps = firs_pkg::Taps
) (
  input  logic [Taps-1:0][firs_pkg::ProdW-1:0] prod_i,
  input  logic                                 block_end_i,
  output firs_pkg::out_t                       result_o
);

  localparam int unsigned AccW   = firs_pkg::AccW;
  localparam int unsigned ShiftW = AccW - firs_pkg::FracShift;

  localparam logic signed [AccW-1:0]   RoundBias = AccW'(1) <<< (firs_pkg::FracShift - 1);
  localparam logic signed [ShiftW-1:0] SatMax    =
    ShiftW'((1 << (firs_pkg::SampleW - 1)) - 1);
  localparam logic signed [ShiftW-1:0] SatMin    =
    -ShiftW'(1 << (firs_pkg::SampleW - 1));

  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   biased;
  logic signed [ShiftW-1:0] scaled;

  // Add up the tap products exactly
  always_comb begin
    acc = '0;
    for (int k = 0; k < Taps; k++) begin
      acc = acc + AccW'($signed(prod_i[k]));
    end
  end

  // Round half up, then drop the fraction bits
  assign biased = acc + RoundBias;
  assign scaled = biased[AccW-1:firs_pkg::FracShift];

  // Clip to the sample range
  always_comb begin
    result_o.block_end_out = block_end_i;
    if (scaled > SatMax) begin
      result_o.sample_out = firs_pkg::SampleW'(SatMax);
      result_o.saturated  = 1'b1;
    end else if (scaled < SatMin) begin
      result_o.sample_out = firs_pkg::SampleW'(SatMin);
      result_o.saturated  = 1'b1;
    end else begin
      result_o.sample_out = scaled[firs_pkg::SampleW-1:0];
      result_o.saturated  = 1'b0;
    end
  end

endmodule

// ===== sv/fir_filter_stream_core.sv =====
`timescale 1ns / 1ps

// Streaming direct-form FIR filter: y[n] = sum of coeff_k * x[n-k] over Taps taps,
// Q1.15 samples, Q2.16 coefficients, exact accumulation, round half up and 16-bit
// saturation. One sample is taken every clock while in_stall_o is low; its tap
// products go to the product register, its clipped sum to the output register.
// The rate is set by one 18x16 multiplier per tap working in parallel, followed
// by the adder tree. A clear transfer zeroes the history and yields no result.
// Coefficients must be written through the config port only while the filter is
// empty, not enforced by the block. After reset, samples pass through unchanged.
module fir_filter_stream_core #(
  parameter int unsigned Taps = firs_pkg::Taps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config port
  input  logic                          cfg_we_i,
  input  logic [firs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [firs_pkg::CoeffW-1:0]   cfg_data_i,
  // Input samples
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  firs_pkg::in_t                 in_data_i,
  // Filtered samples
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output firs_pkg::out_t                out_data_o
);

  `include "fir_filter_stream_core_assert.svh"

  localparam int unsigned ProdW     = firs_pkg::ProdW;
  localparam int unsigned HistDepth = (Taps > 1) ? Taps - 1 : 1;

  logic signed [firs_pkg::CoeffW-1:0]  coeff_q [firs_pkg::NumCoeff];
  logic signed [firs_pkg::SampleW-1:0] hist_q  [HistDepth];

  logic [Taps-1:0][ProdW-1:0] prod_d, prod_q;
  logic                       prod_valid_q;
  logic                       prod_be_q;

  firs_pkg::out_t out_d, out_q;
  logic           out_valid_q;

  logic out_ready;
  logic prod_ready;
  logic in_xfer;
  logic is_clear;
  logic sat_at_limit;

  // Pipeline flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign prod_ready = !prod_valid_q || out_ready;
  assign in_stall_o = !prod_ready;
  assign in_xfer    = in_valid_i && prod_ready;
  assign is_clear   = (in_data_i.func == firs_pkg::FUNC_CLEAR);

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q[0] <= firs_pkg::CoeffOne;
      for (int k = 1; k < firs_pkg::NumCoeff; k++) begin
        coeff_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      coeff_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Sample history: slide on a filter transfer, zero on a clear transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= '0;
      end
    end else if (in_xfer) begin
      if (is_clear) begin
        for (int k = 0; k < HistDepth; k++) begin
          hist_q[k] <= '0;
        end
      end else begin
        for (int k = HistDepth - 1; k > 0; k--) begin
          hist_q[k] <= hist_q[k-1];
        end
        hist_q[0] <= in_data_i.sample_in;
      end
    end
  end

  // Tap products, one multiplier per tap
  always_comb begin
    prod_d    = '0;
    prod_d[0] = ProdW'(coeff_q[0]) * ProdW'(in_data_i.sample_in);
    for (int k = 1; k < Taps; k++) begin
      prod_d[k] = ProdW'(coeff_q[k]) * ProdW'(hist_q[k-1]);
    end
  end

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_q <= in_xfer && !is_clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !is_clear) begin
      prod_q    <= prod_d;
      prod_be_q <= in_data_i.block_end;
    end
  end

  // Sum, round and clip
  firs_sum #(
    .Taps (Taps)
  ) u_sum (
    .prod_i      (prod_q),
    .block_end_i (prod_be_q),
    .result_o    (out_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && prod_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Held result sits at one of the two range limits
  assign sat_at_limit = (out_q.sample_out == 16'sh7fff) || (out_q.sample_out == 16'sh8000);

  // A filter transfer always loads the product stage
  `FIRS_ASSERT(a_filter_loads_prod, in_xfer && !is_clear |=> prod_valid_q, "filter transfer lost")
  // A clear transfer never creates a result
  `FIRS_ASSERT(a_clear_no_result, in_xfer && is_clear |=> !prod_valid_q, "clear made a result")
  // A product moving on always lands in the output register
  `FIRS_ASSERT(a_prod_to_out, prod_valid_q && out_ready |=> out_valid_q, "product dropped")
  // A clipped result sits at a range limit
  `FIRS_ASSERT(a_sat_limit, out_valid_q && out_q.saturated |-> sat_at_limit, "bad clip value")
  // Nothing is valid right after reset
  `FIRS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q || rst_ni, "valid after reset")

endmodule
